### hw/rtl/assert_macros.svh
// assertion macros for the port-level checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication checked outside reset
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### hw/rtl/btc_pkg.sv
// shared types and constants for the boosted tree cascade scorer
// no dependencies
package btc_pkg;
  localparam int TREES_DEF          = 4096;
  localparam int NODES_PER_TREE_DEF = 63;
  localparam int FEATURE_WORDS_DEF  = 131072;
  localparam int CHANNELS_DEF       = 10;
  localparam int MODEL_ROWS_DEF     = 32;
  localparam int MODEL_COLS_DEF     = 16;

  localparam logic [1:0] REQ_NODE = 2'd0;
  localparam logic [1:0] REQ_FEAT = 2'd1;
  localparam logic [1:0] REQ_EVAL = 2'd2;
  localparam logic [1:0] REQ_NONE = 2'd3;

  localparam logic [2:0] CFG_THRESH = 3'd0;
  localparam logic [2:0] CFG_DEPTH  = 3'd1;
  localparam logic [2:0] CFG_COUNT  = 3'd2;
  localparam logic [2:0] CFG_HEIGHT = 3'd3;
  localparam logic [2:0] CFG_WIDTH  = 3'd4;
  localparam logic [2:0] CFG_STEP   = 3'd5;

  // command queued between front and back
  typedef struct packed {
    logic [1:0]  req;
    logic [17:0] node_index;
    logic [15:0] thr;
    logic [15:0] leaf;
    logic [12:0] fid;
    logic [5:0]  child;
    logic [16:0] faddr;
    logic [15:0] fval;
    logic [9:0]  row;
    logic [9:0]  col;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_BASE, ST_TREE, ST_NODE_RD, ST_NODE_WT, ST_FEAT_A,
    ST_FEAT_B, ST_FEAT_RD, ST_FEAT_WT, ST_DECIDE, ST_LEAF, ST_DONE
  } state_t;
endpackage

### hw/rtl/boosted_tree_cascade_window_score.sv
// top level of the boosted tree cascade window scorer
// depends on btc_pkg, btc_front, btc_back
//
// Channels: command input (start/busy) carrying a node load, a feature load
// or a window evaluate; a config write port (cfg_valid/cfg_ready, always
// ready); a result output strobed by out_valid for one cycle per evaluate.
// Loads are written in the back end as they are popped. An evaluate pops
// the command, forms the window base, then per tree reads the node memory
// and, for every tested node, the feature memory one after the other before
// the result; early rejection ends the walk at the first tree whose sum
// falls to or below the cascade threshold. A two-entry queue lets new
// commands be taken while an evaluate runs; busy rises when it is full.
// Reset clears control and sets the registers to their defaults; model
// and feature memories are undefined until loaded. The receiver cannot
// stall: each result is shown for exactly one cycle.
module boosted_tree_cascade_window_score
  import btc_pkg::*;
#(
  parameter int TREES          = TREES_DEF,
  parameter int NODES_PER_TREE = NODES_PER_TREE_DEF,
  parameter int FEATURE_WORDS  = FEATURE_WORDS_DEF,
  parameter int MODEL_ROWS     = MODEL_ROWS_DEF,
  parameter int MODEL_COLS     = MODEL_COLS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [17:0] in_node_index,
  input  logic [15:0] in_node_threshold,
  input  logic signed [15:0] in_node_leaf_value,
  input  logic [12:0] in_node_feature_id,
  input  logic [5:0]  in_node_child,
  input  logic [16:0] in_feature_address,
  input  logic [15:0] in_feature_value,
  input  logic [9:0]  in_window_row,
  input  logic [9:0]  in_window_col,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  output logic signed [31:0] out_score,
  output logic        out_detected,
  output logic [9:0]  out_result_row,
  output logic [9:0]  out_result_col
);
  cmd_t cmd_in, q_cmd;
  logic q_valid, q_pop;
  logic signed [31:0] thresh_r;
  logic [2:0]  depth_r;
  logic [12:0] count_r;
  logic [10:0] height_r, width_r;
  logic [3:0]  step_r;

  assign cfg_ready = 1'b1;
  assign cmd_in = '{req: in_req_type, node_index: in_node_index,
                    thr: in_node_threshold, leaf: in_node_leaf_value,
                    fid: in_node_feature_id, child: in_node_child,
                    faddr: in_feature_address, fval: in_feature_value,
                    row: in_window_row, col: in_window_col};

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= -32'sd4096;
      depth_r  <= 3'd0;
      count_r  <= 13'd4096;
      height_r <= 11'd64;
      width_r  <= 11'd64;
      step_r   <= 4'd2;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_THRESH: thresh_r <= cfg_data;
        CFG_DEPTH:  depth_r  <= cfg_data[2:0];
        CFG_COUNT:  count_r  <= cfg_data[12:0];
        CFG_HEIGHT: height_r <= cfg_data[10:0];
        CFG_WIDTH:  width_r  <= cfg_data[10:0];
        CFG_STEP:   step_r   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  btc_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd_in(cmd_in),
    .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop));

  btc_back #(
    .TREES(TREES), .NODES_PER_TREE(NODES_PER_TREE), .FEATURE_WORDS(FEATURE_WORDS),
    .MODEL_ROWS(MODEL_ROWS), .MODEL_COLS(MODEL_COLS)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
    .thresh(thresh_r), .depth(depth_r), .count(count_r), .height(height_r),
    .width(width_r), .step(step_r), .out_valid(out_valid), .out_score(out_score),
    .out_detected(out_detected), .out_result_row(out_result_row),
    .out_result_col(out_result_col));
endmodule

### hw/rtl/btc_ram.sv
// generic single-port RAM, one write or read per cycle, registered read
// no dependencies
module btc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write or registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end
  assign rdata = rdata_r;
endmodule

### hw/rtl/btc_front.sv
// front end: takes commands, drops unknown codes, two-entry queue to the back end
// depends on btc_pkg
module btc_front
  import btc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  cmd_t        cmd_in,
  output logic        q_valid,
  output cmd_t        q_cmd,
  input  logic        q_pop
);
  cmd_t       ent_r [2];
  logic       rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  // queue is full at two entries; unknown codes are dropped at the door
  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy && (cmd_in.req != REQ_NONE);
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = ent_r[rd_r];

  always_comb begin
    rd_nxt  = rd_r ^ q_pop;
    wr_nxt  = wr_r ^ push;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_r] <= cmd_in;
    end
  end
endmodule

### hw/rtl/btc_back.sv
// back end: memory loads and the tree walk sequencer
// depends on btc_pkg, btc_ram
module btc_back
  import btc_pkg::*;
#(
  parameter int TREES          = TREES_DEF,
  parameter int NODES_PER_TREE = NODES_PER_TREE_DEF,
  parameter int FEATURE_WORDS  = FEATURE_WORDS_DEF,
  parameter int MODEL_ROWS     = MODEL_ROWS_DEF,
  parameter int MODEL_COLS     = MODEL_COLS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  cmd_t               q_cmd,
  output logic               q_pop,
  input  logic signed [31:0] thresh,
  input  logic [2:0]         depth,
  input  logic [12:0]        count,
  input  logic [10:0]        height,
  input  logic [10:0]        width,
  input  logic [3:0]         step,
  output logic               out_valid,
  output logic signed [31:0] out_score,
  output logic               out_detected,
  output logic [9:0]         out_result_row,
  output logic [9:0]         out_result_col
);
  localparam int NT    = TREES * NODES_PER_TREE;
  localparam int NAW   = $clog2(NT);
  localparam int FAW   = $clog2(FEATURE_WORDS);
  localparam int CELLS = MODEL_ROWS * MODEL_COLS;
  localparam int TW    = $clog2(TREES + 1);
  localparam int LW    = $clog2(NODES_PER_TREE + 1) + 1;
  localparam int RW    = $clog2(MODEL_ROWS);
  localparam int NW    = NAW + 1;
  localparam int NODE_W = 16 + 16 + 13 + 6;

  state_t state_r, state_nxt;
  logic [TW-1:0]  tree_r, tree_nxt;
  logic [NW-1:0]  off_r, off_nxt;
  logic [NW-1:0]  node_r, node_nxt;
  logic [LW-1:0]  local_r, local_nxt;
  logic [7:0]     steps_r, steps_nxt;
  logic [2:0]     lvl_r, lvl_nxt;
  logic signed [33:0] h_r, h_nxt;
  logic [39:0]    base_r, base_nxt;
  logic [39:0]    fa_r, fa_nxt;
  logic [31:0]    chm_r, chm_nxt;
  logic [9:0]     row_r, col_r;

  logic              n_we, f_we;
  logic [NAW-1:0]    n_addr;
  logic [FAW-1:0]    f_addr;
  logic [NODE_W-1:0] n_wd, n_rd;
  logic [15:0]       f_rd;
  logic [NODE_W-1:0] nd_r;
  logic [15:0]       n_thr, n_leaf;
  logic [12:0]       n_fid;
  logic [5:0]        n_child;
  logic [TW-1:0]     trees_lim;
  logic [12:0]       ch_id;
  logic [12:0]       rem_id;
  logic [12:0]       col_id;
  logic [RW-1:0]     row_id;
  logic              left;
  logic signed [33:0] hs;

  // node address wrap: the sum is always below twice the node total
  function automatic logic [NW-1:0] wrap_node(logic [31:0] s);
    return NW'((s >= 32'(NT)) ? s - 32'(NT) : s);
  endfunction

  assign {n_thr, n_leaf, n_fid, n_child} = nd_r;
  assign n_wd = {q_cmd.thr, q_cmd.leaf, q_cmd.fid, q_cmd.child};
  assign trees_lim = (count > 13'(TREES)) ? TW'(TREES) : TW'(count);

  // feature id split with constant divisors
  assign ch_id  = 13'(n_fid / CELLS);
  assign rem_id = 13'(n_fid % CELLS);
  assign col_id = 13'(rem_id / MODEL_ROWS);
  assign row_id = RW'(rem_id % MODEL_ROWS);
  assign left   = f_rd < n_thr;
  assign hs     = h_r + 34'(signed'(n_leaf));

  btc_ram #(.WIDTH(NODE_W), .DEPTH(NT)) u_nodes (
    .clk(clk), .we(n_we), .addr(n_addr), .wdata(n_wd), .rdata(n_rd));
  btc_ram #(.WIDTH(16), .DEPTH(FEATURE_WORDS)) u_feat (
    .clk(clk), .we(f_we), .addr(f_addr), .wdata(q_cmd.fval), .rdata(f_rd));

  // state register and walk registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    tree_r  <= tree_nxt;
    off_r   <= off_nxt;
    node_r  <= node_nxt;
    local_r <= local_nxt;
    steps_r <= steps_nxt;
    lvl_r   <= lvl_nxt;
    h_r     <= h_nxt;
    base_r  <= base_nxt;
    fa_r    <= fa_nxt;
    chm_r   <= chm_nxt;
    if (state_r == ST_NODE_WT) begin
      nd_r <= n_rd;
    end
    if (state_r == ST_IDLE && q_valid) begin
      row_r <= q_cmd.row;
      col_r <= q_cmd.col;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    tree_nxt = tree_r; off_nxt = off_r; node_nxt = node_r; local_nxt = local_r;
    steps_nxt = steps_r; lvl_nxt = lvl_r; h_nxt = h_r; base_nxt = base_r;
    fa_nxt = fa_r; chm_nxt = chm_r;
    q_pop = 1'b0; n_we = 1'b0; f_we = 1'b0;
    n_addr = NAW'(node_r);
    f_addr = FAW'(fa_r % FEATURE_WORDS);
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_cmd.req)
            REQ_NODE: begin
              n_addr = NAW'(q_cmd.node_index);
              n_we   = (32'(q_cmd.node_index) < 32'(NT));
            end
            REQ_FEAT: begin
              f_addr = FAW'(q_cmd.faddr % FEATURE_WORDS);
              f_we   = 1'b1;
            end
            default: begin
              base_nxt  = 40'(14'(q_cmd.row) * 14'(step));
              fa_nxt    = 40'(14'(q_cmd.col) * 14'(step));
              chm_nxt   = 32'(22'(height) * 22'(width));
              tree_nxt  = '0;
              off_nxt   = '0;
              h_nxt     = '0;
              state_nxt = ST_BASE;
            end
          endcase
        end
      end
      ST_BASE: begin
        base_nxt  = base_r + 40'(25'(fa_r[13:0]) * 25'(height));
        state_nxt = ST_TREE;
      end
      ST_TREE: begin
        if (tree_r >= trees_lim) begin
          state_nxt = ST_DONE;
        end else begin
          node_nxt  = off_r;
          local_nxt = '0;
          steps_nxt = '0;
          lvl_nxt   = '0;
          state_nxt = ST_NODE_RD;
        end
      end
      ST_NODE_RD: state_nxt = ST_NODE_WT;
      ST_NODE_WT: state_nxt = ST_FEAT_A;
      ST_FEAT_A: begin
        // leaf check before any feature fetch
        if ((depth != 3'd0 && lvl_r == depth) ||
            (depth == 3'd0 && (n_child == 6'd0 || steps_r == 8'(NODES_PER_TREE)))) begin
          state_nxt = ST_LEAF;
        end else begin
          fa_nxt    = 40'(ch_id * chm_r);
          state_nxt = ST_FEAT_B;
        end
      end
      ST_FEAT_B: begin
        fa_nxt    = fa_r + 40'(24'(col_id) * 24'(height)) + 40'(row_id) + base_r;
        state_nxt = ST_FEAT_RD;
      end
      ST_FEAT_RD: state_nxt = ST_FEAT_WT;
      ST_FEAT_WT: state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (depth != 3'd0) begin
          local_nxt = LW'({local_r, 1'b0} + (left ? LW'(1) : LW'(2)));
          lvl_nxt   = lvl_r + 3'd1;
        end else begin
          local_nxt = left ? LW'(n_child - 6'd1) : LW'(n_child);
          steps_nxt = steps_r + 8'd1;
        end
        node_nxt  = wrap_node(32'(off_r) + 32'(local_nxt));
        state_nxt = ST_NODE_RD;
      end
      ST_LEAF: begin
        if (hs > 34'sd2147483647) h_nxt = 34'sd2147483647;
        else if (hs < -34'sd2147483648) h_nxt = -34'sd2147483648;
        else h_nxt = hs;
        tree_nxt = tree_r + TW'(1);
        off_nxt  = wrap_node(32'(off_r) + 32'(NODES_PER_TREE));
        state_nxt = ST_TREE;
        if (h_nxt <= 34'(thresh)) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        out_valid = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_score      = h_r[31:0];
  assign out_detected   = h_r > 34'(thresh);
  assign out_result_row = row_r;
  assign out_result_col = col_r;
endmodule

### hw/rtl/btc_checker.sv
// port-level checks for the cascade scorer, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"
module btc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic signed [31:0] out_score,
  input logic        out_detected,
  input logic        cfg_ready
);
  // a result strobe lasts one cycle
  `CHK_NEXT(a_strobe, clk, rst_n, out_valid, !out_valid, "result strobe held")
  // a detect always carries a score above the lowest value
  `CHK_IMPL(a_det, clk, rst_n, out_valid && out_detected, out_score != 32'sh80000000, "bad detect")
  // config port is always ready
  `CHK_IMPL(a_cfg, clk, rst_n, 1'b1, cfg_ready, "config stalled")
endmodule

bind boosted_tree_cascade_window_score btc_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_score(out_score),
  .out_detected(out_detected), .cfg_ready(cfg_ready));

### sim/btc_score_checker.sv
// checker for the boosted tree cascade window scorer: watches the command,
// config and result channels, keeps its own copy of the model and feature map
// and scores every window. depends on btc_pkg
module btc_score_checker
  import btc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         in_req_type,
  input  logic [17:0]        in_node_index,
  input  logic [15:0]        in_node_threshold,
  input  logic signed [15:0] in_node_leaf_value,
  input  logic [12:0]        in_node_feature_id,
  input  logic [5:0]         in_node_child,
  input  logic [16:0]        in_feature_address,
  input  logic [15:0]        in_feature_value,
  input  logic [9:0]         in_window_row,
  input  logic [9:0]         in_window_col,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               out_valid,
  input  logic signed [31:0] out_score,
  input  logic               out_detected,
  input  logic [9:0]         out_result_row,
  input  logic [9:0]         out_result_col,
  output int                 mismatches,
  output int                 pending,
  output int                 scored
);
  localparam int NODE_TOTAL = TREES_DEF * NODES_PER_TREE_DEF;
  localparam int CELLS      = MODEL_ROWS_DEF * MODEL_COLS_DEF;

  typedef struct {
    logic signed [31:0] score;
    logic               detected;
    logic [9:0]         row;
    logic [9:0]         col;
  } window_score_t;

  // sparse copies of the model and feature memories
  logic [15:0] node_thr[int];
  logic [15:0] node_leaf[int];
  logic [12:0] node_fid[int];
  logic [5:0]  node_child[int];
  logic [15:0] feat_mem[int];

  // register copies
  logic signed [31:0] reject_thr;
  logic [2:0]         depth;
  logic [12:0]        tree_cnt;
  logic [10:0]        height;
  logic [10:0]        width;
  logic [3:0]         step;

  window_score_t expected_scores[$];

  assign pending = expected_scores.size();

  function automatic logic [15:0] rd16(ref logic [15:0] mem[int], input int a);
    return mem.exists(a) ? mem[a] : 16'd0;
  endfunction

  // feature value tested at a node for a window base
  function automatic logic [15:0] feature_at(int node, longint base);
    longint f, ch, rem, a;
    f   = node_fid.exists(node) ? node_fid[node] : 0;
    ch  = f / CELLS;
    rem = f % CELLS;
    a   = ch * height * width + (rem / MODEL_ROWS_DEF) * height + rem % MODEL_ROWS_DEF
          + base;
    return rd16(feat_mem, int'(a % FEATURE_WORDS_DEF));
  endfunction

  function automatic bit goes_left(int node, longint base);
    return feature_at(node, base) < rd16(node_thr, node);
  endfunction

  // walk the cascade for one window
  function automatic window_score_t score_window(logic [9:0] wr, logic [9:0] wc);
    window_score_t r;
    longint base, h;
    int trees, offset, node, loc, c;
    base  = longint'(wr) * step + longint'(wc) * step * height;
    trees = (tree_cnt > TREES_DEF) ? TREES_DEF : int'(tree_cnt);
    h     = 0;
    for (int t = 0; t < trees; t++) begin
      offset = t * NODES_PER_TREE_DEF;
      node   = offset;
      if (depth != 0) begin
        loc = 0;
        for (int d = 0; d < depth; d++) begin
          loc  = loc * 2 + (goes_left(node, base) ? 1 : 2);
          node = (offset + loc) % NODE_TOTAL;
        end
      end else begin
        for (int s = 0; s < NODES_PER_TREE_DEF; s++) begin
          c = node_child.exists(node) ? node_child[node] : 0;
          if (c == 0) break;
          loc  = goes_left(node, base) ? c - 1 : c;
          node = (offset + loc) % NODE_TOTAL;
        end
      end
      h += longint'($signed(rd16(node_leaf, node)));
      if (h > 64'sd2147483647) h = 64'sd2147483647;
      if (h < -64'sd2147483648) h = -64'sd2147483648;
      if (h <= longint'(reject_thr)) break;
    end
    r.score    = h[31:0];
    r.detected = h > longint'(reject_thr);
    r.row      = wr;
    r.col      = wc;
    return r;
  endfunction

  always @(posedge clk) begin
    window_score_t e;
    bit bad;
    if (!rst_n) begin
      reject_thr = -32'sd4096;
      depth      = 3'd0;
      tree_cnt   = 13'd4096;
      height     = 11'd64;
      width      = 11'd64;
      step       = 4'd2;
      expected_scores.delete();
      mismatches = 0;
      scored     = 0;
    end else begin
      // result beat against the oldest expectation
      if (out_valid) begin
        if (expected_scores.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: score %0d row %0d col %0d",
                     out_score, out_result_row, out_result_col);
        end else begin
          e   = expected_scores.pop_front();
          bad = (out_score !== e.score) || (out_detected !== e.detected) ||
                (out_result_row !== e.row) || (out_result_col !== e.col);
          scored++;
          if (bad) begin
            mismatches++;
            if (mismatches <= 10)
              $display("score mismatch: exp %0d/%0b/%0d/%0d got %0d/%0b/%0d/%0d",
                       e.score, e.detected, e.row, e.col, out_score, out_detected,
                       out_result_row, out_result_col);
          end
        end
      end
      // register write beat
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_THRESH: reject_thr = cfg_data;
          CFG_DEPTH:  depth      = cfg_data[2:0];
          CFG_COUNT:  tree_cnt   = cfg_data[12:0];
          CFG_HEIGHT: height     = cfg_data[10:0];
          CFG_WIDTH:  width      = cfg_data[10:0];
          CFG_STEP:   step       = cfg_data[3:0];
          default: ;
        endcase
      end
      // command beat
      if (start && !busy) begin
        case (in_req_type)
          REQ_NODE: begin
            if (in_node_index < NODE_TOTAL) begin
              node_thr[in_node_index]   = in_node_threshold;
              node_leaf[in_node_index]  = in_node_leaf_value;
              node_fid[in_node_index]   = in_node_feature_id;
              node_child[in_node_index] = in_node_child;
            end
          end
          REQ_FEAT: feat_mem[int'(in_feature_address) % FEATURE_WORDS_DEF] = in_feature_value;
          REQ_EVAL: expected_scores.insert(expected_scores.size(),
                                           score_window(in_window_row, in_window_col));
          default: ;
        endcase
      end
    end
  end
endmodule

### sim/tb_boosted_tree_cascade_window_score.sv
// testbench top for the boosted tree cascade window scorer: loads a small model,
// sweeps register settings and fires random loads and window evaluates.
// depends on btc_pkg, btc_score_checker and the scorer rtl
module tb_boosted_tree_cascade_window_score;
  import btc_pkg::*;

  localparam logic [2:0] CFG_SPARE_A = 3'd6;
  localparam logic [2:0] CFG_SPARE_B = 3'd7;
  localparam int NODE_TOTAL  = TREES_DEF * NODES_PER_TREE_DEF;
  localparam int MODEL_NODES = 3 * NODES_PER_TREE_DEF;
  localparam int CELLS       = MODEL_ROWS_DEF * MODEL_COLS_DEF;
  localparam int LIMIT       = 4000000;
  localparam int ITEMS       = 450;

  logic clk, rst_n, start, busy;
  logic [1:0] in_req_type;
  logic [17:0] in_node_index;
  logic [15:0] in_node_threshold;
  logic signed [15:0] in_node_leaf_value;
  logic [12:0] in_node_feature_id;
  logic [5:0] in_node_child;
  logic [16:0] in_feature_address;
  logic [15:0] in_feature_value;
  logic [9:0] in_window_row, in_window_col;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  logic out_valid, out_detected;
  logic signed [31:0] out_score;
  logic [9:0] out_result_row, out_result_col;
  int mismatches, pending, scored;

  boosted_tree_cascade_window_score dut (.*);
  btc_score_checker u_checker (.*);

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // register shadows for feature addressing and reach limits
  int cur_h, cur_w, cur_step;
  logic [12:0] fid_pool[8];
  logic [9:0] row_pool[3], col_pool[3];
  bit feat_loaded[int];
  bit idle_on;
  int n_eval, n_node, n_feat, n_cfg, n_items;

  function automatic cmd_t random_cmd(logic [1:0] req);
    cmd_t c;
    c.req = req;
    c.node_index = 18'($urandom); c.thr = 16'($urandom); c.leaf = 16'($urandom);
    c.fid = 13'($urandom); c.child = 6'($urandom); c.faddr = 17'($urandom);
    c.fval = 16'($urandom); c.row = 10'($urandom); c.col = 10'($urandom);
    return c;
  endfunction

  // one command beat, with an optional idle gap in front
  task automatic issue_cmd(cmd_t c);
    bit ok;
    cfg_valid <= 1'b0;
    if (idle_on && $urandom_range(99) < 22) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= c.req; in_node_index <= c.node_index;
    in_node_threshold <= c.thr; in_node_leaf_value <= c.leaf;
    in_node_feature_id <= c.fid; in_node_child <= c.child;
    in_feature_address <= c.faddr; in_feature_value <= c.fval;
    in_window_row <= c.row; in_window_col <= c.col;
    do begin
      @(negedge clk);
      ok = !busy;
      @(posedge clk);
    end while (!ok);
    n_items++;
  endtask

  // cfg_valid stays up between back-to-back writes and drops with the next command
  task automatic write_reg(logic [2:0] idx, logic [31:0] val, logic [31:0] mask);
    bit ok;
    start <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= (($urandom) & ~mask) | (val & mask);
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    n_cfg++;
  endtask

  // wait for every score, then let queued loads drain
  task automatic settle();
    start <= 1'b0;
    cfg_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_node(int idx, bit pool_fid);
    cmd_t c;
    c = random_cmd(REQ_NODE);
    c.node_index = 18'(idx);
    c.child = 6'($urandom_range(62));
    if (pool_fid) c.fid = fid_pool[$urandom_range(7)];
    issue_cmd(c);
    n_node++;
  endtask

  task automatic load_feature(int addr, logic [15:0] val);
    cmd_t c;
    c = random_cmd(REQ_FEAT);
    c.faddr = 17'(addr);
    c.fval = val;
    issue_cmd(c);
    feat_loaded[addr] = 1'b1;
    n_feat++;
  endtask

  function automatic int feat_addr(logic [12:0] f, logic [9:0] wr, logic [9:0] wc);
    longint rem, a;
    rem = f % CELLS;
    a = longint'(f / CELLS) * cur_h * cur_w
        + (longint'(wc) * cur_step + rem / MODEL_ROWS_DEF) * cur_h
        + longint'(wr) * cur_step + rem % MODEL_ROWS_DEF;
    return int'(a % FEATURE_WORDS_DEF);
  endfunction

  // make sure every word the window can touch has been written
  task automatic eval_window(logic [9:0] wr, logic [9:0] wc);
    cmd_t c;
    int a;
    for (int i = 0; i < 8; i++) begin
      a = feat_addr(fid_pool[i], wr, wc);
      if (!feat_loaded.exists(a)) load_feature(a, 16'($urandom));
    end
    c = random_cmd(REQ_EVAL);
    c.row = wr;
    c.col = wc;
    issue_cmd(c);
    n_eval++;
  endtask

  task automatic set_regs(logic [31:0] thr, int depth, int count, int h, int w, int stp);
    write_reg(CFG_THRESH, thr, 32'hffffffff);
    write_reg(CFG_DEPTH, depth, 32'h7);
    write_reg(CFG_COUNT, count, 32'h1fff);
    write_reg(CFG_HEIGHT, h, 32'h7ff);
    write_reg(CFG_WIDTH, w, 32'h7ff);
    write_reg(CFG_STEP, stp, 32'hf);
    cur_h = h; cur_w = w; cur_step = stp;
  endtask

  initial begin
    int depth, tcmax, count, h, w, stp, r, quota, ph;
    logic [31:0] thr;
    rst_n = 1'b0; start = 1'b0; cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    in_req_type = '0; in_node_index = '0; in_node_threshold = '0;
    in_node_leaf_value = '0; in_node_feature_id = '0; in_node_child = '0;
    in_feature_address = '0; in_feature_value = '0; in_window_row = '0;
    in_window_col = '0;
    idle_on = 1'b1;
    fid_pool[0] = 13'd0; fid_pool[1] = 13'd5119; fid_pool[2] = 13'd3072;
    fid_pool[3] = 13'd1;
    for (int i = 4; i < 8; i++) fid_pool[i] = 13'($urandom_range(5119));
    cur_h = 64; cur_w = 64; cur_step = 2;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // model: the first three trees, feature ids from a fixed pool
    for (int i = 0; i < MODEL_NODES; i++) load_node(i, 1'b1);
    settle();

    // directed: count past the tree total with a top threshold rejects at tree one
    set_regs(32'h7fffffff, 0, 8191, 64, 64, 2);
    write_reg(CFG_SPARE_A, $urandom, 32'hffffffff);
    write_reg(CFG_SPARE_B, $urandom, 32'hffffffff);
    eval_window(10'd0, 10'd0);
    eval_window(10'd1023, 10'd1023);
    issue_cmd(random_cmd(REQ_NONE));
    load_node(NODE_TOTAL, 1'b0);
    load_node(18'h3ffff, 1'b0);
    load_node(NODE_TOTAL - 1, 1'b0);
    load_feature(0, 16'hffff);
    load_feature(FEATURE_WORDS_DEF - 1, 16'h0000);
    eval_window(10'd0, 10'd1023);
    settle();
    write_reg(CFG_COUNT, 0, 32'h1fff);
    eval_window(10'd5, 10'd7);
    settle();

    // random phases over register settings
    ph = 0;
    while (n_items < ITEMS || ph < 5) begin
      settle();
      idle_on = (ph != 3);
      depth = (ph == 0) ? 0 : (ph == 1) ? 6 : $urandom_range(6);
      h = (ph % 3 == 0) ? 1 : (ph % 3 == 1) ? 1024 : $urandom_range(1024, 1);
      w = (ph % 3 == 1) ? 1 : (ph % 3 == 2) ? 1024 : $urandom_range(1024, 1);
      stp = (ph == 2) ? 8 : (ph == 3) ? 1 : $urandom_range(8, 1);
      case (ph % 4)
        0: thr = 32'h80000000;
        1: thr = $urandom_range(80000) - 40000;
        2: thr = $urandom;
        default: thr = 32'h0;
      endcase
      tcmax = (MODEL_NODES - 1 - ((depth == 0) ? 62 : (1 << (depth + 1)) - 2))
              / NODES_PER_TREE_DEF + 1;
      count = $urandom_range(tcmax, 1);
      if (ph == 4) begin
        thr = 32'h7fffffff;
        count = $urandom_range(8191, 4096);
      end
      set_regs(thr, depth, count, h, w, stp);
      row_pool[0] = 10'd0; row_pool[1] = 10'd1023; row_pool[2] = 10'($urandom);
      col_pool[0] = 10'd1023; col_pool[1] = 10'd0; col_pool[2] = 10'($urandom);
      quota = 15;
      while (quota > 0) begin
        r = $urandom_range(99);
        if (r < 40) begin
          eval_window(row_pool[$urandom_range(2)], col_pool[$urandom_range(2)]);
        end else if (r < 65) begin
          if ($urandom_range(9) == 0) load_node($urandom_range(18'h3ffff, MODEL_NODES), 1'b0);
          else load_node($urandom_range(MODEL_NODES - 1), 1'b1);
        end else if (r < 92) begin
          load_feature($urandom_range(FEATURE_WORDS_DEF - 1), 16'($urandom));
        end else begin
          issue_cmd(random_cmd(REQ_NONE));
          continue;
        end
        quota--;
      end
      ph++;
    end

    settle();
    $display("run covered %0d window scores, %0d node loads, %0d feature loads",
             scored, n_node, n_feat);
    $display("and %0d register writes across depth, count, map and step sweeps", n_cfg);
    if (mismatches == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule
